// ----- rtl/stdm_pkg.sv -----
// shared constants, types and the mask weight table for the stdm embedder
package stdm_pkg;

	localparam int unsigned ELEMS      = 16;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned COEF_W     = 24;
	localparam int unsigned STEP_W     = 23;
	localparam int unsigned FACT_W     = 16;
	localparam int unsigned KEY_W      = 14;
	localparam int unsigned QUOT_W     = 28;
	localparam int unsigned ACC_W      = 48;
	localparam int unsigned MUL_A_W    = 41;
	localparam int unsigned MUL_B_W    = 18;
	localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
	localparam int unsigned WEIGHT_W   = 15;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMP_FACT  = 2'd1;

	localparam logic [STEP_W-1:0] STEP_RESET = 23'd2560;
	localparam logic [FACT_W-1:0] FACT_RESET = 16'd45875;

	typedef struct packed {
		logic                 start;
		logic [QUOT_W-1:0]    dividend;
		logic [STEP_W-1:0]    divisor;
	} mod_req_t;

	typedef struct packed {
		logic                 done;
		logic [STEP_W-1:0]    rem;
	} mod_rsp_t;

	function automatic logic [WEIGHT_W-1:0] weight(input logic [IDX_W-1:0] k);
		logic [WEIGHT_W-1:0] w;
		unique case (k)
			4'd0:  w = 15'd0;
			4'd1:  w = 15'd1660;
			4'd2:  w = 15'd3434;
			4'd3:  w = 15'd6840;
			4'd4:  w = 15'd1660;
			4'd5:  w = 15'd3205;
			4'd6:  w = 15'd4264;
			4'd7:  w = 15'd6583;
			4'd8:  w = 15'd3434;
			4'd9:  w = 15'd4264;
			4'd10: w = 15'd8786;
			4'd11: w = 15'd12450;
			4'd12: w = 15'd6840;
			4'd13: w = 15'd6583;
			4'd14: w = 15'd12450;
			4'd15: w = 15'd20750;
			default: w = 15'd0;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/stdm_watermark_block_embed.sv -----
// top level of the stdm embedder: load, sequencer, shared multiplier and result port
// Coefficients of one 4x4 block are taken one per cycle while busy is low, row-major.
// On the sixteenth the block raises busy and works on one shared multiplier and a
// bit-serial remainder unit: two remainder passes (28 quotient bits and a hand-off each),
// marking each coefficient through multiply, add, accumulate and sum states, sequencing,
// and sending the marked coefficients. The 16 results come on consecutive cycles marked
// by strobe, registered behind the emit state, so the last one arrives in the first cycle
// that busy is low again. The results cannot be held off. Configuration writes are always
// taken (cfg_ready is high).
module stdm_watermark_block_embed (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [23:0]            coefficient,
	input  logic [13:0]                   key_offset,
	input  logic                          message_bit,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stdm_pkg::STEP_W-1:0]   cfg_data,
	output logic                          strobe,
	output logic signed [23:0]            marked_coefficient,
	output logic                          last_of_block,
	output logic                          decoded_bit,
	output logic                          embed_error
);

	typedef enum logic [13:0] {
		ST_LOAD  = 14'b00000000000001,
		ST_FLUSH = 14'b00000000000010,
		ST_DITH  = 14'b00000000000100,
		ST_PREP  = 14'b00000000001000,
		ST_MODW  = 14'b00000000010000,
		ST_ERR   = 14'b00000000100000,
		ST_WMUL  = 14'b00000001000000,
		ST_WGT   = 14'b00000010000000,
		ST_MKMUL = 14'b00000100000000,
		ST_MKADD = 14'b00001000000000,
		ST_MKACC = 14'b00010000000000,
		ST_MKSUM = 14'b00100000000000,
		ST_THR   = 14'b01000000000000,
		ST_EMIT  = 14'b10000000000000
	} state_t;

	state_t                                 state_q;
	logic [stdm_pkg::STEP_W-1:0]            step_q;
	logic [stdm_pkg::FACT_W-1:0]            fact_q;
	logic [stdm_pkg::IDX_W-1:0]             cnt_q;
	logic [stdm_pkg::KEY_W-1:0]             key_q;
	logic                                   bit_q;
	logic                                   pass2_q;
	logic                                   prod_vld_q;
	logic signed [stdm_pkg::ACC_W-1:0]      acc_q;
	logic signed [stdm_pkg::PROD_W-1:0]     prod_q;
	logic                                   neg_q;
	logic [15:0]                            low_q;
	logic signed [39:0]                     e_q;
	logic signed [39:0]                     w_q;
	logic signed [23:0]                     mk_q;
	logic                                   dec_q;
	logic signed [23:0]                     store [stdm_pkg::ELEMS];
	logic                                   strobe_q;
	logic signed [23:0]                     out_coef_q;
	logic                                   out_last_q;
	logic                                   out_dec_q;
	logic                                   out_err_q;

	logic [stdm_pkg::STEP_W-1:0]            s_eff;
	logic                                   accept;
	logic signed [stdm_pkg::MUL_A_W-1:0]    mul_a;
	logic signed [stdm_pkg::MUL_B_W-1:0]    mul_b;
	logic signed [stdm_pkg::PROD_W-1:0]     mul_p;
	logic [stdm_pkg::WEIGHT_W-1:0]          wk;
	logic signed [43:0]                     x_val;
	logic signed [43:0]                     y_val;
	logic signed [27:0]                     y_hi;
	logic [stdm_pkg::STEP_W-1:0]            r_small;
	logic signed [39:0]                     e_val;
	logic signed [stdm_pkg::PROD_W-1:0]     w_sum;
	logic signed [stdm_pkg::PROD_W-1:0]     d_sum;
	logic signed [27:0]                     delta;
	logic signed [27:0]                     mk_sum;
	logic signed [23:0]                     mk_sat;
	logic [39:0]                            e_abs;
	stdm_pkg::mod_req_t                     mreq;
	stdm_pkg::mod_rsp_t                     mrsp;

	assign s_eff     = (step_q == '0) ? 23'd1 : step_q;
	assign accept    = start && (state_q == ST_LOAD);
	assign busy      = (state_q != ST_LOAD);
	assign cfg_ready = 1'b1;
	assign wk        = stdm_pkg::weight(cnt_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_LOAD: begin
				mul_a = 41'(coefficient);
				mul_b = 18'({1'b0, wk});
			end
			ST_DITH: begin
				mul_a = 41'({1'b0, s_eff});
				mul_b = pass2_q ? 18'({1'b0, key_q}) : 18'({bit_q, 15'd0} + {2'b0, key_q});
			end
			ST_WMUL: begin
				mul_a = 41'(e_q);
				mul_b = 18'({1'b0, fact_q});
			end
			ST_MKMUL: begin
				mul_a = 41'(w_q);
				mul_b = 18'({1'b0, wk});
			end
			ST_MKACC: begin
				mul_a = 41'(mk_q);
				mul_b = 18'({1'b0, wk});
			end
			ST_THR: begin
				mul_a = 41'({1'b0, s_eff});
				mul_b = 18'(17'h10000 - {1'b0, fact_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign x_val = {acc_q[42:0], 1'b0} - prod_q[43:0];
	assign y_val = x_val + 44'({s_eff, 15'd0});
	assign y_hi  = y_val[43:16];

	assign r_small = (neg_q && mrsp.rem != '0) ? (s_eff - mrsp.rem) : mrsp.rem;
	assign e_val   = 40'({s_eff, 15'd0}) - 40'({r_small, low_q});

	assign w_sum  = prod_q + 59'sd32768;
	assign d_sum  = prod_q + (59'sd1 <<< 30);
	assign delta  = d_sum[58:31];
	assign mk_sum = 28'(store[cnt_q]) + delta;
	assign mk_sat = (mk_sum > 28'sd8388607) ? 24'sh7FFFFF :
	                (mk_sum < -28'sd8388608) ? 24'sh800000 : mk_sum[23:0];
	assign e_abs  = e_q[39] ? 40'(-e_q) : 40'(e_q);

	assign mreq.start    = (state_q == ST_PREP);
	assign mreq.dividend = y_hi[27] ? 28'(-y_hi) : 28'(y_hi);
	assign mreq.divisor  = s_eff;

	stdm_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			step_q     <= stdm_pkg::STEP_RESET;
			fact_q     <= stdm_pkg::FACT_RESET;
			cnt_q      <= '0;
			key_q      <= '0;
			bit_q      <= 1'b0;
			pass2_q    <= 1'b0;
			prod_vld_q <= 1'b0;
			acc_q      <= '0;
			strobe_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == stdm_pkg::REG_STEP_SIZE)
					step_q <= cfg_data;
				else if (cfg_index == stdm_pkg::REG_COMP_FACT)
					fact_q <= cfg_data[stdm_pkg::FACT_W-1:0];
			end
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (prod_vld_q)
						acc_q <= acc_q + 48'(prod_q);
					prod_vld_q <= accept;
					if (accept) begin
						if (cnt_q == '0) begin
							key_q <= key_offset;
							bit_q <= message_bit;
						end
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == 4'(stdm_pkg::ELEMS - 1))
							state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					acc_q      <= acc_q + 48'(prod_q);
					prod_vld_q <= 1'b0;
					state_q    <= ST_DITH;
				end
				ST_DITH:  state_q <= ST_PREP;
				ST_PREP: begin
					acc_q   <= '0;
					state_q <= ST_MODW;
				end
				ST_MODW: begin
					if (mrsp.done)
						state_q <= ST_ERR;
				end
				ST_ERR:   state_q <= pass2_q ? ST_THR : ST_WMUL;
				ST_WMUL:  state_q <= ST_WGT;
				ST_WGT: begin
					cnt_q   <= '0;
					state_q <= ST_MKMUL;
				end
				ST_MKMUL: state_q <= ST_MKADD;
				ST_MKADD: state_q <= ST_MKACC;
				ST_MKACC: state_q <= ST_MKSUM;
				ST_MKSUM: begin
					acc_q <= acc_q + 48'(prod_q);
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(stdm_pkg::ELEMS - 1)) begin
						pass2_q <= 1'b1;
						state_q <= ST_DITH;
					end else begin
						state_q <= ST_MKMUL;
					end
				end
				ST_THR: begin
					cnt_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					cnt_q    <= cnt_q + 4'd1;
					if (cnt_q == 4'(stdm_pkg::ELEMS - 1)) begin
						pass2_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			store[cnt_q] <= coefficient;
		if (state_q == ST_MKADD) begin
			store[cnt_q] <= mk_sat;
			mk_q         <= mk_sat;
		end
		if (state_q == ST_LOAD || state_q == ST_DITH || state_q == ST_WMUL ||
		    state_q == ST_MKMUL || state_q == ST_MKACC || state_q == ST_THR)
			prod_q <= mul_p;
		if (state_q == ST_PREP) begin
			neg_q <= y_hi[27];
			low_q <= y_val[15:0];
		end
		if (state_q == ST_ERR)
			e_q <= e_val;
		if (state_q == ST_WGT)
			w_q <= w_sum[55:16];
		if (state_q == ST_EMIT) begin
			if (cnt_q == '0)
				dec_q <= !({e_abs[38:0], 1'b0} < prod_q[39:0]);
			out_coef_q <= store[cnt_q];
			out_last_q <= (cnt_q == 4'(stdm_pkg::ELEMS - 1));
			out_dec_q  <= (cnt_q == '0) ? !({e_abs[38:0], 1'b0} < prod_q[39:0]) : dec_q;
			out_err_q  <= ((cnt_q == '0) ? !({e_abs[38:0], 1'b0} < prod_q[39:0]) : dec_q)
			              != bit_q;
		end
	end

	assign strobe             = strobe_q;
	assign marked_coefficient = out_coef_q;
	assign last_of_block      = out_last_q && strobe_q;
	assign decoded_bit        = out_dec_q;
	assign embed_error        = out_err_q;

`ifndef SYNTHESIS
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_block |=> strobe) else $error("result burst broken");
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cnt_q == 4'(stdm_pkg::ELEMS - 1) |=> busy)
		else $error("block not busy after last coefficient");
	a_no_strobe_load: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_block |-> busy) else $error("results while loading");
`endif

endmodule

// ----- rtl/stdm_mod_unit.sv -----
// bit-serial restoring remainder unit, one quotient bit per cycle
module stdm_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  stdm_pkg::mod_req_t req,
	output stdm_pkg::mod_rsp_t rsp
);

	logic [stdm_pkg::QUOT_W-1:0] dvd_q;
	logic [stdm_pkg::STEP_W-1:0] dvs_q;
	logic [stdm_pkg::STEP_W:0]   rem_q;
	logic [4:0]                  cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [stdm_pkg::STEP_W:0]   shifted;
	logic [stdm_pkg::STEP_W:0]   trial;

	assign shifted = {rem_q[stdm_pkg::STEP_W-1:0], dvd_q[stdm_pkg::QUOT_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(stdm_pkg::QUOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[stdm_pkg::QUOT_W-2:0], 1'b0};
			rem_q <= trial[stdm_pkg::STEP_W] ? shifted : trial;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[stdm_pkg::STEP_W-1:0];

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("remainder done held");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < {1'b0, dvs_q})) else $error("remainder not reduced");
	a_run_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !done_q) else $error("done while running");
`endif

endmodule
